>>> src/gci_pkg.sv
`default_nettype none
package gci_pkg;

  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam int unsigned GridDepth = MaxPoints * MaxPoints;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  // divider: (diff << 16) / step, 48 quotient bits, two per cycle
  localparam int unsigned DivBits     = 48;
  localparam int unsigned DivPerCycle = 2;
  localparam int unsigned DivCycles   = DivBits / DivPerCycle;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  localparam logic [CfgIdxW-1:0] REG_POINTS_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POINTS_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_X    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_Y    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STEP_X   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STEP_Y   = 3'd7;

  typedef struct packed {
    logic [4:0]         points_x;
    logic [4:0]         points_y;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic [30:0]        step_x;
    logic [30:0]        step_y;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    points_x: 5'd16, points_y: 5'd16,
    min_x: 32'sd0, min_y: 32'sd0,
    max_x: 32'sd983040, max_y: 32'sd983040,
    step_x: 31'd65536, step_y: 31'd65536
  };

  typedef struct packed {
    kind_e              kind;
    logic [IdxW-1:0]    index_x;
    logic [IdxW-1:0]    index_y;
    logic signed [31:0] entry_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               deriv_x;
    logic               deriv_y;
    logic               outside;
  } item_t;

endpackage
`default_nettype wire

>>> src/gci_front.sv
`default_nettype none
module gci_front import gci_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic               tvalid_i,
  output logic               tready_o,
  input  logic [InDataW-1:0] tdata_i,
  input  logic [InUserW-1:0] tuser_i,
  input  logic               full_i,
  output logic               push_o,
  output item_t              item_o
);

  logic signed [31:0] cx, cy;

  assign cx = tdata_i[71:40];
  assign cy = tdata_i[103:72];

  assign tready_o = !full_i;
  assign push_o   = tvalid_i && !full_i;

  always_comb begin
    item_o.kind        = kind_e'(tuser_i);
    item_o.index_x     = tdata_i[3:0];
    item_o.index_y     = tdata_i[7:4];
    item_o.entry_value = tdata_i[39:8];
    item_o.coord_x     = cx;
    item_o.coord_y     = cy;
    item_o.deriv_x     = tdata_i[104];
    item_o.deriv_y     = tdata_i[105];
    // range check up front; also catches min > max
    item_o.outside     = (cx < cfg_i.min_x) || (cx > cfg_i.max_x) ||
                         (cy < cfg_i.min_y) || (cy > cfg_i.max_y);
  end

endmodule
`default_nettype wire

>>> src/gci_fifo.sv
`default_nettype none
module gci_fifo import gci_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t             q_mem [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = q_mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) q_mem[wptr_q] <= item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");

endmodule
`default_nettype wire

>>> src/gci_back.sv
`default_nettype none
module gci_back import gci_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         empty_i,
  input  item_t        item_i,
  output logic         pop_o,
  input  logic         m_tready_i,
  output logic         m_tvalid_o,
  output logic [31:0]  m_result_o,
  output logic         m_status_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_GATHER = 3'd3;
  localparam logic [2:0] S_CUBIC  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [16:0]        FracOne = 17'h10000;
  localparam logic signed [49:0] Lim40   = 50'sh100_0000_0000;
  localparam logic [4:0]         DivLast = 5'(DivCycles - 1);

  function automatic logic [4:0] eff_n(input logic [4:0] n);
    if (n < 5'd2) return 5'd2;
    if (n > 5'(MaxPoints)) return 5'(MaxPoints);
    return n;
  endfunction

  // entry index on one axis; sec picks the second (next-inward) entry
  function automatic logic [IdxW-1:0] nb_idx(input logic signed [5:0] pos,
                                             input logic [4:0] n, input logic sec);
    logic [4:0] last;
    last = n - 5'd1;
    if (pos < 0) return sec ? IdxW'(1) : IdxW'(0);
    if (pos > $signed({1'b0, last})) return sec ? IdxW'(n - 5'd2) : IdxW'(last);
    return pos[IdxW-1:0];
  endfunction

  function automatic logic signed [41:0] clamp40(input logic signed [49:0] v);
    if (v > Lim40) return 42'(Lim40);
    if (v < -Lim40) return 42'(-Lim40);
    return v[41:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -42'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic [2:0]   state_q, state_d;
  item_t        it_q;

  // grid memory with per-entry valid bits (reset reads as zero)
  logic [31:0]          mem_q [GridDepth];
  logic [GridDepth-1:0] vld_q;
  logic [31:0]          rd_q;
  logic                 rdv_q;
  logic [AddrW-1:0]     raddr_w, waddr_w;
  logic                 we_w;
  logic [31:0]          wdata_w;
  logic signed [31:0]   rdata_w;
  logic signed [32:0]   sum_w;
  logic signed [31:0]   sum_sat_w;

  logic [4:0]  nx_w, ny_w;
  logic [30:0] stx_w, sty_w, dsor_w;

  // divider
  logic [30:0] rem_q, rem_nx;
  logic [47:0] quo_q, quo_nx;
  logic [4:0]  dcnt_q;
  logic        axis_q;
  logic [31:0] diffx_w, diffy_w;
  logic [4:0]  lim_w;
  logic        over_w;
  logic [IdxW-1:0] cell_w;
  logic [16:0] frac_w;
  logic [IdxW-1:0] cell_x_q, cell_y_q;
  logic [16:0] fx_q, fy_q;

  // gather
  logic [5:0]  rk_q;
  logic        dv_q;
  logic [4:0]  dk_q;
  logic signed [31:0] g1_q;
  logic signed [33:0] nb_q [4][4];
  logic signed [5:0]  posx_w, posy_w;

  // cubic
  logic [2:0]  ci_q, cs_q;
  logic signed [49:0] p_w [4];
  logic signed [49:0] a_w, b_w, c_w;
  logic signed [49:0] ra_q, rb_q, rc_q, rp1_q, t_q;
  logic signed [49:0] op_w, pre_w;
  logic signed [67:0] mul_w;
  logic signed [49:0] tnx_w;
  logic signed [41:0] cres_w;
  logic signed [41:0] row_q [4];
  logic [16:0] fsel_w;
  logic        dsel_w;
  logic        cfin_w;

  logic signed [31:0] res_q;
  logic        stat_q;
  logic        ov_q;
  logic [31:0] od_q;
  logic        os_q;
  logic        out_load_w;

  assign nx_w  = eff_n(cfg_i.points_x);
  assign ny_w  = eff_n(cfg_i.points_y);
  assign stx_w = (cfg_i.step_x == '0) ? 31'd1 : cfg_i.step_x;
  assign sty_w = (cfg_i.step_y == '0) ? 31'd1 : cfg_i.step_y;
  assign dsor_w = axis_q ? sty_w : stx_w;

  assign diffx_w = 32'(33'(item_i.coord_x) - 33'(cfg_i.min_x));
  assign diffy_w = 32'(33'(it_q.coord_y) - 33'(cfg_i.min_y));

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  always_comb begin : p_div
    logic [30:0] r;
    logic [47:0] qq;
    logic [31:0] r2;
    logic        ge;
    r  = rem_q;
    qq = quo_q;
    for (int b = 0; b < DivPerCycle; b++) begin
      r2 = {r, qq[47]};
      ge = r2 >= {1'b0, dsor_w};
      qq = {qq[46:0], ge};
      r  = ge ? 31'(r2 - {1'b0, dsor_w}) : r2[30:0];
    end
    rem_nx = r;
    quo_nx = qq;
  end

  // past the last grid point: last cell, fraction 1.0
  assign lim_w  = (axis_q ? ny_w : nx_w) - 5'd2;
  assign over_w = quo_nx[47:16] > {27'd0, lim_w};
  assign cell_w = over_w ? lim_w[IdxW-1:0] : quo_nx[16+IdxW-1:16];
  assign frac_w = over_w ? FracOne : {1'b0, quo_nx[15:0]};

  assign posx_w = $signed({2'b00, cell_x_q}) + $signed({4'b0000, rk_q[4:3]}) - 6'sd1;
  assign posy_w = $signed({2'b00, cell_y_q}) + $signed({4'b0000, rk_q[2:1]}) - 6'sd1;

  always_comb begin
    if (state_q == S_GATHER) begin
      raddr_w = {nb_idx(posx_w, nx_w, rk_q[0]), nb_idx(posy_w, ny_w, rk_q[0])};
    end else begin
      raddr_w = {item_i.index_x, item_i.index_y};
    end
  end

  assign rdata_w   = rdv_q ? rd_q : 32'sd0;
  assign sum_w     = 33'(rdata_w) + 33'(it_q.entry_value);
  assign sum_sat_w = sat32(42'(sum_w));

  always_comb begin
    we_w    = 1'b0;
    waddr_w = {it_q.index_x, it_q.index_y};
    wdata_w = sum_sat_w;
    if (state_q == S_ADD) begin
      we_w = 1'b1;
    end else if (pop_o && item_i.kind == KIND_WRITE) begin
      we_w    = 1'b1;
      waddr_w = {item_i.index_x, item_i.index_y};
      wdata_w = item_i.entry_value;
    end
  end

  // cubic operands: rows of the neighbourhood first, then the row results
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_w[k] = ci_q[2] ? 50'(row_q[k]) : 50'(nb_q[ci_q[1:0]][k]);
    end
  end

  assign a_w = p_w[2] - p_w[0];
  assign b_w = (p_w[0] <<< 1) - ((p_w[1] <<< 2) + p_w[1]) + (p_w[2] <<< 2) - p_w[3];
  assign c_w = ((p_w[1] - p_w[2]) <<< 1) + (p_w[1] - p_w[2]) + p_w[3] - p_w[0];

  assign fsel_w = ci_q[2] ? fx_q : fy_q;
  assign dsel_w = ci_q[2] ? it_q.deriv_x : it_q.deriv_y;

  always_comb begin
    unique case (cs_q)
      3'd1:    op_w = dsel_w ? (rc_q + (rc_q <<< 1)) : rc_q;
      3'd2:    op_w = (dsel_w ? (rb_q <<< 1) : rb_q) + t_q;
      3'd3:    op_w = ra_q + t_q;
      default: op_w = '0;
    endcase
  end

  assign mul_w = op_w * $signed({1'b0, fsel_w});
  assign tnx_w = mul_w[65:16];

  assign pre_w  = (cs_q == 3'd3) ? ((ra_q + t_q) >>> 1) : (rp1_q + (t_q >>> 1));
  assign cres_w = clamp40(pre_w);
  assign cfin_w = (cs_q == 3'd4) || (cs_q == 3'd3 && dsel_w);

  assign out_load_w = (state_q == S_DONE) && (!ov_q || m_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          unique case (item_i.kind)
            KIND_ADD:   state_d = S_ADD;
            KIND_QUERY: state_d = item_i.outside ? S_DONE : S_DIV;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_ADD:    state_d = S_DONE;
      S_DIV:    if (dcnt_q == DivLast && axis_q) state_d = S_GATHER;
      S_GATHER: if (dv_q && dk_q == 5'd31) state_d = S_CUBIC;
      S_CUBIC:  if (cfin_w && ci_q[2]) state_d = S_DONE;
      S_DONE:   if (out_load_w) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
      dcnt_q  <= '0;
      axis_q  <= 1'b0;
      rk_q    <= '0;
      dv_q    <= 1'b0;
      ci_q    <= '0;
      cs_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (we_w) vld_q[waddr_w] <= 1'b1;
      if (out_load_w) ov_q <= 1'b1;
      else if (m_tready_i) ov_q <= 1'b0;

      if (state_q == S_IDLE) begin
        dcnt_q <= '0;
        axis_q <= 1'b0;
      end else if (state_q == S_DIV) begin
        if (dcnt_q == DivLast) begin
          dcnt_q <= '0;
          axis_q <= 1'b1;
        end else begin
          dcnt_q <= dcnt_q + 5'd1;
        end
      end

      if (state_q == S_GATHER) begin
        dv_q <= !rk_q[5];
        if (!rk_q[5]) rk_q <= rk_q + 6'd1;
      end else begin
        rk_q <= '0;
        dv_q <= 1'b0;
      end

      if (state_q == S_CUBIC) begin
        if (cfin_w) begin
          cs_q <= '0;
          ci_q <= ci_q + 3'd1;
        end else begin
          cs_q <= cs_q + 3'd1;
        end
      end else begin
        cs_q <= '0;
        ci_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_w) mem_q[waddr_w] <= wdata_w;
    rd_q  <= mem_q[raddr_w];
    rdv_q <= vld_q[raddr_w];

    if (pop_o) begin
      it_q   <= item_i;
      res_q  <= (item_i.kind == KIND_WRITE) ? item_i.entry_value : 32'sd0;
      stat_q <= (item_i.kind == KIND_QUERY) && item_i.outside;
      rem_q  <= '0;
      quo_q  <= {diffx_w, 16'd0};
    end

    if (state_q == S_ADD) res_q <= sum_sat_w;

    if (state_q == S_DIV) begin
      if (dcnt_q == DivLast) begin
        if (axis_q) begin
          cell_y_q <= cell_w;
          fy_q     <= frac_w;
        end else begin
          cell_x_q <= cell_w;
          fx_q     <= frac_w;
          rem_q    <= '0;
          quo_q    <= {diffy_w, 16'd0};
        end
      end else begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
      end
    end

    dk_q <= rk_q[4:0];
    if (dv_q) begin
      if (!dk_q[0]) g1_q <= rdata_w;
      else nb_q[dk_q[4:3]][dk_q[2:1]] <= (34'(g1_q) <<< 1) - 34'(rdata_w);
    end

    if (state_q == S_CUBIC) begin
      if (cs_q == 3'd0) begin
        ra_q  <= a_w;
        rb_q  <= b_w;
        rc_q  <= c_w;
        rp1_q <= p_w[1];
      end else if (!cfin_w) begin
        t_q <= tnx_w;
      end else if (!ci_q[2]) begin
        row_q[ci_q[1:0]] <= cres_w;
      end else begin
        res_q <= sat32(cres_w);
      end
    end

    if (out_load_w) begin
      od_q <= res_q;
      os_q <= stat_q;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_result_o = od_q;
  assign m_status_o = os_q;

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> ({1'b0, rem_q} < {1'b0, dsor_w}))
    else $error("divider remainder not below divisor");

  a_ci_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CUBIC) |-> (ci_q <= 3'd4))
    else $error("cubic index out of range");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == S_DONE))
    else $error("result shown without finished item");

endmodule
`default_nettype wire

>>> src/grid_cubic_interpolator_unit.sv
// Grid interpolator: 16x16 grid of Q16.16 samples with Catmull-Rom lookup.
// Input beats (s_axis_*): tuser carries the action (write, add, query);
// tdata carries entry index, value, query point and derivative flags.
// Every accepted beat yields exactly one output beat (m_axis_*): tdata is
// the new entry value or the interpolated value, tuser the range status.
// A two-entry queue sits between the input decode and the execution
// sequencer, so input keeps being taken while a result waits on m_axis.
// A write stores the entry and an add adds to it, each returning the new value;
// an out-of-range query skips the later steps and returns with status set. An
// in-range query runs the two bounding-cell divisions (two quotient bits per
// cycle), reads the 32 grid entries of the 4x4 neighbourhood through the single
// memory read port, then runs five cubic evaluations on the shared multiplier.
// Items are executed one at a time in arrival order; a queued item starts only
// once the result of the item before it has been loaded for m_axis.
// Reset clears the grid (per-entry valid bits) and loads the default
// configuration; no clearing pass runs after reset. When m_axis_tready is
// low the result is held, the sequencer waits, and once the queue is full
// s_axis_tready drops. Configuration writes apply at once; the user is to
// make them only while no item is in flight; the block does not enforce this.
`default_nettype none
module grid_cubic_interpolator_unit import gci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // index_x, index_y, entry_value, coord_x, coord_y, deriv_x, deriv_y, zero fill
  input  logic [InDataW-1:0] s_axis_tdata,
  // action
  input  logic [InUserW-1:0] s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // result_value
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [0:0]         m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t  cfg_q;
  item_t fr_item, q_item;
  logic  push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POINTS_X: cfg_q.points_x <= cfg_data_i[4:0];
        REG_POINTS_Y: cfg_q.points_y <= cfg_data_i[4:0];
        REG_MIN_X:    cfg_q.min_x    <= cfg_data_i;
        REG_MIN_Y:    cfg_q.min_y    <= cfg_data_i;
        REG_MAX_X:    cfg_q.max_x    <= cfg_data_i;
        REG_MAX_Y:    cfg_q.max_y    <= cfg_data_i;
        REG_STEP_X:   cfg_q.step_x   <= cfg_data_i[30:0];
        REG_STEP_Y:   cfg_q.step_y   <= cfg_data_i[30:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  gci_front u_front (
    .cfg_i    (cfg_q),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .tdata_i  (s_axis_tdata),
    .tuser_i  (s_axis_tuser),
    .full_i   (full),
    .push_o   (push),
    .item_o   (fr_item)
  );

  gci_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (q_item)
  );

  gci_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .item_i     (q_item),
    .pop_o      (pop),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_result_o (m_axis_tdata),
    .m_status_o (m_axis_tuser[0])
  );

endmodule
`default_nettype wire

>>> verif/grid_cubic_interpolator_unit_test.sv
`default_nettype none
module grid_cubic_interpolator_unit_test;
  import gci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e       kind;
    logic [3:0]  ix;
    logic [3:0]  iy;
    logic [31:0] val;
    logic [31:0] cx;
    logic [31:0] cy;
    logic        dx;
    logic        dy;
  } beat_t;

  typedef struct {
    logic [31:0] value;
    logic        status;
  } answer_t;

  localparam longint Lim40 = 64'sd1 << 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  grid_cubic_interpolator_unit DUT (.*);

  beat_t pending_beats[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int accepted = 0;
  int answered = 0;
  int queries = 0;
  int in_range = 0;
  longint cycles = 0;

  // shadow grid and registers
  logic signed [31:0] grid_m[16][16];
  logic [4:0]  pts_x = 5'd16, pts_y = 5'd16;
  longint      lo_x = 0, lo_y = 0, hi_x = 983040, hi_y = 983040;
  logic [30:0] stp_x = 31'd65536, stp_y = 31'd65536;

  function automatic void add_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clip40(longint v);
    if (v > Lim40) return Lim40;
    if (v < -Lim40) return -Lim40;
    return v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int used_points(logic [4:0] n);
    if (n < 2) return 2;
    if (n > 16) return 16;
    return n;
  endfunction

  function automatic bit find_cell(longint c, longint lo, longint hi, logic [30:0] stp,
                                   int n, output int bin, output longint frac);
    longint unsigned diff, idx, st;
    bin = 0;
    frac = 0;
    if (c < lo || c > hi) return 0;
    st = (stp == 0) ? 1 : stp;
    diff = c - lo;
    idx = diff / st;
    if (idx > n - 2) begin
      bin = n - 2;
      frac = 65536;
    end else begin
      bin = int'(idx);
      frac = ((diff - idx * st) << 16) / st;
    end
    return 1;
  endfunction

  function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                     longint f, bit slope);
    longint a, b, c, t;
    a = p2 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = 3 * (p1 - p2) + p3 - p0;
    if (slope) begin
      t = fl16(3 * c * f);
      t = fl16((2 * b + t) * f);
      return clip40((a + t) >>> 1);
    end
    t = fl16(c * f);
    t = fl16((b + t) * f);
    t = fl16((a + t) * f);
    return clip40(p1 + (t >>> 1));
  endfunction

  function automatic void edge_pair(int pos, int n, output int e1, output int e2,
                                    output bit outside);
    outside = 1;
    if (pos < 0) begin e1 = 0; e2 = 1; end
    else if (pos > n - 1) begin e1 = n - 1; e2 = n - 2; end
    else begin e1 = pos; e2 = pos; outside = 0; end
  endfunction

  function automatic answer_t interpolate_beat(beat_t b);
    answer_t r;
    int nx, ny, bx, by, x1, x2, y1, y2;
    bit ox, oy;
    longint fx, fy, res;
    longint col[4];
    longint rowv[4];
    r.value = '0;
    r.status = 1'b0;
    case (b.kind)
      KIND_WRITE: begin
        grid_m[b.ix][b.iy] = b.val;
        r.value = b.val;
      end
      KIND_ADD: begin
        res = clip32(longint'(grid_m[b.ix][b.iy]) + longint'($signed(b.val)));
        grid_m[b.ix][b.iy] = res[31:0];
        r.value = res[31:0];
      end
      KIND_QUERY: begin
        queries++;
        nx = used_points(pts_x);
        ny = used_points(pts_y);
        if (!find_cell(longint'($signed(b.cx)), lo_x, hi_x, stp_x, nx, bx, fx) ||
            !find_cell(longint'($signed(b.cy)), lo_y, hi_y, stp_y, ny, by, fy)) begin
          r.status = 1'b1;
        end else begin
          in_range++;
          for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
              edge_pair(bx + i - 1, nx, x1, x2, ox);
              edge_pair(by + j - 1, ny, y1, y2, oy);
              if (ox || oy) col[j] = 2 * longint'(grid_m[x1][y1]) - longint'(grid_m[x2][y2]);
              else col[j] = grid_m[x1][y1];
            end
            rowv[i] = catmull(col[0], col[1], col[2], col[3], fy, b.dy);
          end
          res = clip32(catmull(rowv[0], rowv[1], rowv[2], rowv[3], fx, b.dx));
          r.value = res[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      accepted <= accepted + 1;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        beat_t b;
        answer_t a;
        b = pending_beats.pop_front();
        a = interpolate_beat(b);
        expected_answers = {expected_answers, a};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= b.kind;
        s_axis_tdata <= {6'd0, b.dy, b.dx, b.cy, b.cx, b.val, b.iy, b.ix};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (m_axis_tvalid && m_axis_tready) begin
      answered <= answered + 1;
      if (expected_answers.size() == 0) begin
        $error("result beat with nothing expected: value %h", m_axis_tdata);
        errors = errors + 1;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (m_axis_tdata !== e.value) begin
          $error("result_value: expected %h, got %h", e.value, m_axis_tdata);
          errors = errors + 1;
        end
        if (m_axis_tuser[0] !== e.status) begin
          $error("status: expected %b, got %b", e.status, m_axis_tuser[0]);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    wait (cycles > 64'd3000000);
    $display("timeout after %0d cycles", cycles);
    $display("FAILURE");
    $finish;
  end

  function automatic beat_t mk(kind_e k, int ix, int iy, logic [31:0] v, logic [31:0] cx,
                               logic [31:0] cy, bit dx, bit dy);
    beat_t b;
    b.kind = k; b.ix = 4'(ix); b.iy = 4'(iy); b.val = v;
    b.cx = cx; b.cy = cy; b.dx = dx; b.dy = dy;
    return b;
  endfunction

  // coordinate mostly inside [lo, hi], sometimes at or past the bounds
  function automatic logic [31:0] pick_coord(longint lo, longint hi);
    longint span;
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return $urandom;
      3: return lo - 1;
      4: return hi + 1;
      default: begin
        span = hi - lo;
        if (span <= 0) return lo;
        return lo + ((longint'($urandom) << 16 | $urandom_range(65535)) % (span + 1));
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic beat_t rand_beat();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return mk(KIND_WRITE, $urandom_range(15), $urandom_range(15), rand_value(),
                           $urandom, $urandom, $urandom_range(1), $urandom_range(1));
    if (sel < 45) return mk(KIND_ADD, $urandom_range(15), $urandom_range(15), rand_value(),
                           $urandom, $urandom, $urandom_range(1), $urandom_range(1));
    if (sel < 97) return mk(KIND_QUERY, $urandom_range(15), $urandom_range(15), $urandom,
                           pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y),
                           $urandom_range(1), $urandom_range(1));
    return mk(KIND_NONE, $urandom_range(15), $urandom_range(15), $urandom,
              $urandom, $urandom, $urandom_range(1), $urandom_range(1));
  endfunction

  task automatic drain();
    wait (pending_beats.size() == 0);
    while (expected_answers.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_POINTS_X: pts_x = data[4:0];
      REG_POINTS_Y: pts_y = data[4:0];
      REG_MIN_X:    lo_x = longint'($signed(data));
      REG_MIN_Y:    lo_y = longint'($signed(data));
      REG_MAX_X:    hi_x = longint'($signed(data));
      REG_MAX_Y:    hi_y = longint'($signed(data));
      REG_STEP_X:   stp_x = data[30:0];
      default:      stp_y = data[30:0];
    endcase
  endtask

  task automatic load_grid(int px, int py, longint lx, longint ly, int sx, int sy);
    set_reg(REG_POINTS_X, px);
    set_reg(REG_POINTS_Y, py);
    set_reg(REG_MIN_X, 32'(lx));
    set_reg(REG_MIN_Y, 32'(ly));
    set_reg(REG_STEP_X, sx);
    set_reg(REG_STEP_Y, sy);
    set_reg(REG_MAX_X, 32'(lx + longint'(sx) * (used_points(px) - 1)));
    set_reg(REG_MAX_Y, 32'(ly + longint'(sy) * (used_points(py) - 1)));
  endtask

  initial begin
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) grid_m[i][j] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero grid, bounds, past last point, write/add extremes, unused action
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'd0, 32'd0, 0, 0));
    add_beat(mk(KIND_QUERY, 15, 15, 32'hffffffff, 32'd983040, 32'd983040, 1, 1));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'hffffffff, 32'd100, 0, 0));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'd100, 32'd983041, 0, 0));
    add_beat(mk(KIND_WRITE, 0, 0, 32'h7fffffff, 0, 0, 0, 0));
    add_beat(mk(KIND_ADD, 0, 0, 32'd1, 0, 0, 0, 0));
    add_beat(mk(KIND_WRITE, 15, 15, 32'h80000000, 0, 0, 1, 1));
    add_beat(mk(KIND_ADD, 15, 15, 32'hffffffff, 0, 0, 0, 0));
    add_beat(mk(KIND_WRITE, 1, 1, 32'h00030000, 0, 0, 0, 0));
    add_beat(mk(KIND_WRITE, 2, 1, 32'hfffe8000, 0, 0, 0, 0));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'h00018000, 32'h00010000, 0, 0));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'h00018000, 32'h00014000, 1, 0));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'h00008000, 32'h0000c000, 0, 1));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'h000f0000, 32'h0, 1, 1));
    add_beat(mk(KIND_NONE, 15, 15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1));
    add_beat(mk(KIND_QUERY, 0, 0, 0, 32'h0, 32'h000f0000, 0, 0));
    drain();

    // config phases, including extremes of points, bounds and step
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (ph)
        0: load_grid(16, 16, 0, 0, 65536, 65536);
        1: load_grid(2, 2, -65536, 32768, 65536, 12345);
        2: load_grid(0, 31, -200000, -300000, 1, 3);
        3: load_grid(5, 9, 1000, -1000, 70000, 40000);
        4: begin
          load_grid(16, 16, 32'h80000000, 32'h80000000, 31'h08888888, 31'h08888888);
          set_reg(REG_MAX_X, 32'h7fffffff);
          set_reg(REG_MAX_Y, 32'h7fffffff);
        end
        5: begin
          load_grid(7, 3, 0, 0, 0, 65536);
          set_reg(REG_MAX_Y, 32'h7fffffff);
        end
        6: begin
          load_grid(4, 4, 65536, 65536, 31'h7fffffff, 31'h7fffffff);
          set_reg(REG_MAX_X, 32'h7fffffff);
          set_reg(REG_MAX_Y, 32'h7fffffff);
        end
        7: begin
          load_grid(12, 6, 0, 0, 65536, 65536);
          set_reg(REG_MIN_X, 32'd500000);  // min above max: every query out
          set_reg(REG_MAX_X, 32'd1000);
        end
        default: load_grid(16, 16, -500000, 400000, 98304, 30000);
      endcase
      for (int k = 0; k < 100; k++) add_beat(rand_beat());
      drain();
    end

    $display("%0d beats checked, %0d queries (%0d in range) over 9 grid settings",
             answered, queries, in_range);
    $display("with idle sender, stalled receiver and both; %0d errors", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
